FILE: src/chm_pkg.sv
package chm_pkg;

   localparam logic [1:0] CMD_PUT    = 2'd0;
   localparam logic [1:0] CMD_GET    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int KEY_W = 31;
   localparam int VAL_W = 32;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] read_value;
      logic             status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, start bucket index
      logic head;       // finish bucket index, read bucket head
      logic rd_entry;   // read entry at current link
      logic step;       // evaluate entry just read
      logic alloc;      // allocate and append new entry
      logic finish;     // load response register
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       cur_valid;   // current link points at an entry
      logic       match;       // entry read matches the key
      logic       walk_done;   // step limit reached
   } sts_type;

endpackage

FILE: src/chained_hash_map.sv
// Chained hash map: put, get and remove on 31-bit keys over a fixed entry pool.
// Request channel req_valid/req_stall/req_payload (cmd, key, value); response
// channel rsp_valid/rsp_stall/rsp_payload (found, read_value, status).
// Exactly one response per request, in request order.
// One request is in flight at a time. From acceptance to response valid, a
// request multiplies the key by a reciprocal, forms the bucket and reads its
// head, visits the chain entries in turn, then loads the response. A put of a
// new key adds a step for the append. Each chain entry is read from the pool
// memory by address, then evaluated from registered read data. A remove walks
// the whole chain. No new request is taken before the last one is answered;
// the next one can be taken in the same cycle as the response is raised.
// Reset empties every bucket (per-bucket valid bits) and the free stack at once;
// no clearing pass is needed, so requests may arrive in the first cycle.
// When the receiver stalls, the response holds in its output register; the
// next request is taken and worked on, and waits in its final state until the
// register frees.
module chained_hash_map #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chm_pkg::rsp_type rsp_payload
);

   chm_pkg::ctl_type ctl;
   chm_pkg::sts_type sts;

   chm_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .ctl(ctl)
   );

   chm_datapath #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_datapath (
      .clock(clock), .reset(reset),
      .req_payload(req_payload), .ctl(ctl), .sts(sts),
      .rsp_payload(rsp_payload)
   );

endmodule

FILE: src/chm_datapath.sv
module chm_datapath #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  chm_pkg::req_type  req_payload,
   input  chm_pkg::ctl_type  ctl,
   output chm_pkg::sts_type  sts,
   output chm_pkg::rsp_type  rsp_payload
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam logic [LW-1:0] NONE = LW'(ENTRIES);

   // bucket = key mod BUCKETS: quotient by rounded-up reciprocal, exact for
   // every key of KEY_W bits, then key minus quotient times BUCKETS
   localparam int RW = chm_pkg::KEY_W + 2;
   localparam int PW = chm_pkg::KEY_W + RW;
   localparam int RS = chm_pkg::KEY_W + BW;
   localparam longint unsigned RECIP =
      ((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
   localparam logic [BW-1:0] BKT_C = BW'(BUCKETS);

   // head memory, valid bits give the empty reset state
   logic [LW-1:0] head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [chm_pkg::KEY_W-1:0] key_mem  [ENTRIES];
   logic [chm_pkg::VAL_W-1:0] val_mem  [ENTRIES];
   logic [LW-1:0]             next_mem [ENTRIES];
   logic [IW-1:0]             free_mem [ENTRIES];

   chm_pkg::req_type  req_ff;
   logic [PW-1:0]     prod_ff;
   logic [BW-1:0]     bkt_ff;
   logic [LW-1:0]     cur_ff, prev_ff;
   logic [LW-1:0]     steps_ff;
   logic [LW-1:0]     free_cnt_ff, fresh_ff;
   logic [chm_pkg::KEY_W-1:0] rk_ff;
   logic [chm_pkg::VAL_W-1:0] rv_ff;
   logic [LW-1:0]     rn_ff;
   logic [IW-1:0]     fs_rd_ff;
   logic              found_ff, status_ff;
   logic [chm_pkg::VAL_W-1:0] rdv_ff;
   chm_pkg::rsp_type  rsp_ff;

   logic [BW-1:0]   quot_lo;
   logic [2*BW-1:0] quot_mul;
   logic [BW-1:0]   bkt_c;
   logic          cur_is;
   logic          match;
   logic [LW-1:0] alloc_idx;
   logic          alloc_ok;

   assign quot_lo = prod_ff[RS +: BW];
   assign quot_mul = quot_lo * BKT_C;
   assign bkt_c = req_ff.key[BW-1:0] - quot_mul[BW-1:0];

   assign cur_is = (cur_ff < NONE);
   assign match = (rk_ff == req_ff.key);
   assign alloc_ok = (free_cnt_ff != '0) || (fresh_ff < NONE);
   assign alloc_idx = (free_cnt_ff != '0) ? LW'(fs_rd_ff) : fresh_ff;

   assign sts.cmd = req_ff.cmd;
   assign sts.cur_valid = cur_is;
   assign sts.match = match;
   assign sts.walk_done = (steps_ff == NONE);

   // free stack top is read ahead so it is ready for an allocation
   always_ff @(posedge clock) begin
      fs_rd_ff <= free_mem[IW'(free_cnt_ff - LW'(1))];
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_entry) begin
         rk_ff <= key_mem[cur_ff[IW-1:0]];
         rv_ff <= val_mem[cur_ff[IW-1:0]];
         rn_ff <= next_mem[cur_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_payload;
         prod_ff <= {{RW{1'b0}}, req_payload.key} * {{chm_pkg::KEY_W{1'b0}}, RECIP_V};
         prev_ff <= NONE;
         steps_ff <= '0;
         found_ff <= 1'b0;
         status_ff <= 1'b0;
         rdv_ff <= '1;
      end else if (ctl.head) begin
         bkt_ff <= bkt_c;
         cur_ff <= head_vld_ff[bkt_c] ? head_mem[bkt_c] : NONE;
      end else if (ctl.step) begin
         if (match && req_ff.cmd == chm_pkg::CMD_REMOVE) begin
            if (prev_ff < NONE) next_mem[prev_ff[IW-1:0]] <= rn_ff;
            else head_mem[bkt_ff] <= rn_ff;
            if (free_cnt_ff < NONE) free_mem[free_cnt_ff[IW-1:0]] <= cur_ff[IW-1:0];
            found_ff <= 1'b1;
            cur_ff <= rn_ff;
            steps_ff <= steps_ff + LW'(1);
         end else if (match) begin
            found_ff <= 1'b1;
            if (req_ff.cmd == chm_pkg::CMD_GET) rdv_ff <= rv_ff;
            else val_mem[cur_ff[IW-1:0]] <= req_ff.value;
         end else begin
            prev_ff <= cur_ff;
            cur_ff <= rn_ff;
            steps_ff <= steps_ff + LW'(1);
         end
      end else if (ctl.alloc) begin
         if (alloc_ok) begin
            key_mem[alloc_idx[IW-1:0]] <= req_ff.key;
            val_mem[alloc_idx[IW-1:0]] <= req_ff.value;
            next_mem[alloc_idx[IW-1:0]] <= NONE;
            if (prev_ff < NONE) next_mem[prev_ff[IW-1:0]] <= alloc_idx;
            else head_mem[bkt_ff] <= alloc_idx;
         end else begin
            status_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         free_cnt_ff <= '0;
         fresh_ff <= '0;
      end else if (ctl.step && match && req_ff.cmd == chm_pkg::CMD_REMOVE) begin
         if (prev_ff >= NONE) head_vld_ff[bkt_ff] <= 1'b1;
         if (free_cnt_ff < NONE) free_cnt_ff <= free_cnt_ff + LW'(1);
      end else if (ctl.alloc && alloc_ok) begin
         if (prev_ff >= NONE) head_vld_ff[bkt_ff] <= 1'b1;
         if (free_cnt_ff != '0) free_cnt_ff <= free_cnt_ff - LW'(1);
         else fresh_ff <= fresh_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_ff.found <= found_ff;
         rsp_ff.read_value <= rdv_ff;
         rsp_ff.status <= status_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   // walk never runs past the pool size
   assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> steps_ff < NONE)
      else $error("chain walk exceeded pool size");

   assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= NONE && fresh_ff <= NONE)
      else $error("pool counters out of range");

   assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && (ctl.step || ctl.alloc)))
      else $error("conflicting datapath commands");

endmodule

FILE: src/chm_control.sv
module chm_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  chm_pkg::sts_type sts,
   output chm_pkg::ctl_type ctl
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_ALLOC = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       take;
   logic       is_cmd;

   assign is_cmd = (sts.cmd == chm_pkg::CMD_PUT) || (sts.cmd == chm_pkg::CMD_GET)
                   || (sts.cmd == chm_pkg::CMD_REMOVE);
   assign req_stall = (state_ff != ST_IDLE);
   assign take = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               ctl.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_CHECK: begin
            if (!is_cmd) state_in = ST_DONE;
            else if (sts.cur_valid && !sts.walk_done) begin
               ctl.rd_entry = 1'b1;
               state_in = ST_EVAL;
            end else if (sts.cmd == chm_pkg::CMD_PUT) state_in = ST_ALLOC;
            else state_in = ST_DONE;
         end
         // form the bucket index and fetch its head
         ST_READ: begin
            ctl.head = 1'b1;
            state_in = ST_CHECK;
         end
         ST_EVAL: begin
            ctl.step = 1'b1;
            if (sts.match && sts.cmd != chm_pkg::CMD_REMOVE) state_in = ST_DONE;
            else state_in = ST_CHECK;
         end
         ST_ALLOC: begin
            ctl.alloc = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the previous response has gone
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == ST_READ)
      else $error("accepted request not started");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctl))
      else $error("more than one datapath command");

endmodule

FILE: tb/chained_hash_map_checker.sv
`timescale 1ns / 1ps

module chained_hash_map_checker #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  chm_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  chm_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending
);

   localparam int NIL = ENTRIES;

   int      head_of[BUCKETS];
   logic [chm_pkg::KEY_W-1:0] pool_key[ENTRIES];
   logic [chm_pkg::VAL_W-1:0] pool_val[ENTRIES];
   int      pool_next[ENTRIES];
   int      free_list[ENTRIES];
   int      free_depth;
   int      fresh_top;
   chm_pkg::rsp_type answers[$];

   function automatic int grab_entry();
      if (free_depth > 0) begin
         free_depth--;
         return free_list[free_depth];
      end
      if (fresh_top < ENTRIES) begin
         fresh_top++;
         return fresh_top - 1;
      end
      return NIL;
   endfunction

   function automatic chm_pkg::rsp_type apply_request(chm_pkg::req_type r);
      chm_pkg::rsp_type o;
      int b, cur, prev, nxt, steps, hit;
      o.found = 1'b0;
      o.read_value = '1;
      o.status = 1'b0;
      b = int'(r.key % BUCKETS);
      if (r.cmd == chm_pkg::CMD_PUT || r.cmd == chm_pkg::CMD_GET) begin
         cur = head_of[b];
         prev = NIL;
         hit = NIL;
         steps = 0;
         while (cur < ENTRIES && steps < ENTRIES && hit == NIL) begin
            if (pool_key[cur] == r.key) hit = cur;
            else begin
               prev = cur;
               cur = pool_next[cur];
               steps++;
            end
         end
         if (hit != NIL) begin
            o.found = 1'b1;
            if (r.cmd == chm_pkg::CMD_GET) o.read_value = pool_val[hit];
            else pool_val[hit] = r.value;
         end else if (r.cmd == chm_pkg::CMD_PUT) begin
            nxt = grab_entry();
            if (nxt < ENTRIES) begin
               pool_key[nxt] = r.key;
               pool_val[nxt] = r.value;
               pool_next[nxt] = NIL;
               if (prev < ENTRIES) pool_next[prev] = nxt;
               else head_of[b] = nxt;
            end else begin
               o.status = 1'b1;
            end
         end
      end else if (r.cmd == chm_pkg::CMD_REMOVE) begin
         cur = head_of[b];
         prev = NIL;
         steps = 0;
         while (cur < ENTRIES && steps < ENTRIES) begin
            nxt = pool_next[cur];
            if (pool_key[cur] == r.key) begin
               if (prev < ENTRIES) pool_next[prev] = nxt;
               else head_of[b] = nxt;
               if (free_depth < ENTRIES) begin
                  free_list[free_depth] = cur;
                  free_depth++;
               end
               o.found = 1'b1;
            end else begin
               prev = cur;
            end
            cur = nxt;
            steps++;
         end
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      chm_pkg::rsp_type want;
      if (reset) begin
         foreach (head_of[i]) head_of[i] = NIL;
         free_depth = 0;
         fresh_top = 0;
         answers.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            answers.insert(answers.size(), apply_request(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (want.found !== rsp_payload.found
                   || want.read_value !== rsp_payload.read_value
                   || want.status !== rsp_payload.status) begin
                  if (fail_count < 10)
                     $display("mismatch: expected found %b value %h status %b, got %b %h %b",
                              want.found, want.read_value, want.status, rsp_payload.found,
                              rsp_payload.read_value, rsp_payload.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending = answers.size();
   end

endmodule

FILE: tb/chained_hash_map_tb.sv
`timescale 1ns / 1ps

module chained_hash_map_tb;

   localparam int LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   chm_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   chm_pkg::rsp_type rsp_payload;
   int      fail_count;
   int      pending;
   int      quiet_cycles = 0;
   logic [chm_pkg::KEY_W-1:0] key_set[8];

   always #10 clock = ~clock;

   chained_hash_map i_dut (.*);

   chained_hash_map_checker i_check (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stall pattern: bursts of random stalling, some stretches none
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 199) < 2) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= $urandom_range(0, 2) == 0;
      else if ($urandom_range(0, 20) == 0) rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // valid stays up across back-to-back requests and drops only for a gap
   task automatic send(logic [1:0] c, logic [chm_pkg::KEY_W-1:0] k,
                       logic [chm_pkg::VAL_W-1:0] v);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_payload <= '{cmd: c, key: k, value: v};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and hold until every outstanding response has been checked
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   function automatic logic [chm_pkg::KEY_W-1:0] bucket_key(int b);
      return chm_pkg::KEY_W'(($urandom_range(0, 32767) << 8) | b);
   endfunction

   initial begin
      int pick;
      logic [1:0] c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every operation, update, misses, unused command
      send(chm_pkg::CMD_GET, 31'd0, '0);
      send(chm_pkg::CMD_REMOVE, 31'd0, '0);
      send(chm_pkg::CMD_PUT, 31'd0, 32'h8000_0000);
      send(chm_pkg::CMD_PUT, 31'h7fff_ffff, 32'h7fff_ffff);
      send(chm_pkg::CMD_PUT, 31'd256, 32'hffff_ffff);
      send(chm_pkg::CMD_PUT, 31'd2339, 32'd0);
      send(chm_pkg::CMD_GET, 31'd0, '0);
      send(chm_pkg::CMD_GET, 31'h7fff_ffff, '0);
      send(chm_pkg::CMD_GET, 31'd256, '0);
      send(chm_pkg::CMD_PUT, 31'd0, 32'h1234_5678);
      send(chm_pkg::CMD_GET, 31'd0, '0);
      send(chm_pkg::CMD_GET, 31'd512, '0);
      send(chm_pkg::CMD_UNUSED, 31'h5555_5555, 32'haaaa_aaaa);
      send(chm_pkg::CMD_REMOVE, 31'd0, '0);
      send(chm_pkg::CMD_GET, 31'd256, '0);
      send(chm_pkg::CMD_REMOVE, 31'd256, '0);
      send(chm_pkg::CMD_REMOVE, 31'd256, '0);
      send(chm_pkg::CMD_PUT, 31'd768, 32'd5);
      send(chm_pkg::CMD_GET, 31'd768, '0);
      // hold off until the block drains
      drain();
      @(posedge clock);
      // random: small key set on few buckets to build chains
      foreach (key_set[i]) key_set[i] = bucket_key($urandom_range(0, 2));
      for (int n = 0; n < 380; n++) begin
         pick = $urandom_range(0, 99);
         c = pick < 45 ? chm_pkg::CMD_PUT : pick < 75 ? chm_pkg::CMD_GET :
             pick < 97 ? chm_pkg::CMD_REMOVE : chm_pkg::CMD_UNUSED;
         if ($urandom_range(0, 9) < 8)
            send(c, key_set[$urandom_range(0, 7)], $urandom);
         else
            send(c, chm_pkg::KEY_W'($urandom), $urandom);
         if (n == 200) begin
            drain();
            @(posedge clock);
         end
      end
      send(chm_pkg::CMD_PUT, 31'h7000_0001, 32'd9);
      send(chm_pkg::CMD_REMOVE, 31'h4000_0005, '0);
      send(chm_pkg::CMD_PUT, 31'h7000_0001, 32'd9);
      send(chm_pkg::CMD_GET, 31'h7000_0001, '0);
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
